// File: hdl/chtwa_pkg.sv
`default_nettype none
package chtwa_pkg;

  localparam int BUCKETS = 1024;
  localparam int IDX_W   = $clog2(BUCKETS);
  localparam int WAYS    = 4;
  localparam int WAY_W   = $clog2(WAYS);

  localparam logic [7:0] GEN_MAX = 8'hFF;
  localparam logic [7:0] GEN_ONE = 8'h01;

  typedef enum logic [1:0] {
    CMD_PROBE      = 2'd0,
    CMD_STORE      = 2'd1,
    CMD_NEW_SEARCH = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_e;

  typedef struct packed {
    logic        v;
    logic [7:0]  gen;
    logic [31:0] sig;
    logic [5:0]  depth;
    logic [1:0]  flag;
    logic [15:0] score;
    logic [15:0] eval;
    logic        has;
    logic [15:0] mv;
  } slot_t;

  typedef slot_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic load;
    logic gen_adv;
    logic gen_clr;
    logic gen_wrap;
    logic sweep;
    logic probe_done;
    logic store_done;
  } ctl_cmd_t;

  typedef struct packed {
    logic       gen_at_max;
    logic       sweep_last;
    logic       out_free;
    logic [7:0] cur_gen;
    logic [7:0] oldest_gen;
  } ctl_sts_t;

endpackage
`default_nettype wire

// File: hdl/chtwa_ctrl.sv
`default_nettype none
module chtwa_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic [1:0]          in_cmd_i,
  output logic                     in_ready_o,
  input  wire chtwa_pkg::ctl_sts_t sts_i,
  output chtwa_pkg::ctl_cmd_t      cmd_o
);
  import chtwa_pkg::*;

  localparam logic [1:0] S_SWEEP = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [1:0] cmd_q, cmd_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd_i inside {CMD_PROBE, CMD_STORE}) begin
            cmd_o.load = 1'b1;
            cmd_d      = in_cmd_i;
            state_d    = S_EXEC;
          end else if (sts_i.gen_at_max) begin
            cmd_o.gen_wrap = 1'b1;
            state_d        = S_SWEEP;
          end else begin
            cmd_o.gen_adv = 1'b1;
            cmd_o.gen_clr = (in_cmd_i == CMD_CLEAR);
          end
        end
      end
      S_EXEC: begin
        if (cmd_q == CMD_STORE) begin
          cmd_o.store_done = 1'b1;
          state_d          = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.probe_done = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      cmd_q   <= CMD_PROBE;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/chtwa_dp.sv
`default_nettype none
module chtwa_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire chtwa_pkg::ctl_cmd_t cmd_i,
  output chtwa_pkg::ctl_sts_t      sts_o,
  input  wire logic                cfg_we_i,
  input  wire logic [15:0]         cfg_wdata_i,
  input  wire logic [63:0]         key_i,
  input  wire logic [7:0]          depth_i,
  input  wire logic [1:0]          bound_flag_i,
  input  wire logic [15:0]         score_i,
  input  wire logic [15:0]         pos_eval_i,
  input  wire logic                has_move_i,
  input  wire logic [15:0]         best_move_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [58:0]              out_data_o
);
  import chtwa_pkg::*;

  row_t mem [BUCKETS];
  row_t row_q;

  logic [IDX_W-1:0] bucket_q;
  logic [IDX_W-1:0] sweep_cnt_q;
  logic [31:0]      sig_q;
  logic [5:0]       depth_q;
  logic [1:0]       flag_q;
  logic [15:0]      score_q;
  logic [15:0]      eval_q;
  logic             has_q;
  logic [15:0]      mv_q;
  logic [15:0]      marker_q;
  logic [7:0]       cur_q;
  logic [7:0]       old_q;
  logic             out_valid_q;
  logic [58:0]      out_q;

  logic [5:0]       nd;
  logic             found;
  logic [9:0]       best_qual;
  logic [WAY_W-1:0] best_w;
  logic             m_found;
  logic [WAY_W-1:0] m_w;
  logic             f_found;
  logic [WAY_W-1:0] f_w;
  logic [7:0]       vic_qual;
  logic [WAY_W-1:0] v_w;
  logic [9:0]       q;
  logic [7:0]       vq;
  logic             live;
  slot_t            nxt;
  slot_t            old;
  slot_t            bs;
  row_t             new_row;
  logic [58:0]      probe_res;

  always_comb begin
    if (depth_i[7]) begin
      nd = 6'd0;
    end else if (depth_i[6]) begin
      nd = 6'd63;
    end else begin
      nd = depth_i[5:0];
    end
  end

  always_comb begin
    found     = 1'b0;
    best_qual = '0;
    best_w    = '0;
    m_found   = 1'b0;
    m_w       = '0;
    f_found   = 1'b0;
    f_w       = '0;
    vic_qual  = '0;
    v_w       = '0;
    q         = '0;
    vq        = '0;
    live      = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      live = row_q[w].v && row_q[w].gen != 8'd0 && row_q[w].gen >= old_q &&
             row_q[w].gen <= cur_q;
      q = {row_q[w].gen == cur_q, row_q[w].depth, row_q[w].flag == 2'd0, 1'b0,
           row_q[w].has};
      if (live && row_q[w].sig == sig_q && (!found || q > best_qual)) begin
        found     = 1'b1;
        best_qual = q;
        best_w    = w[WAY_W-1:0];
      end
      if (!m_found && row_q[w].v && row_q[w].gen == cur_q && row_q[w].sig == sig_q) begin
        m_found = 1'b1;
        m_w     = w[WAY_W-1:0];
      end
      if (!f_found && (!row_q[w].v || row_q[w].gen != cur_q)) begin
        f_found = 1'b1;
        f_w     = w[WAY_W-1:0];
      end
      vq = {row_q[w].depth, row_q[w].flag == 2'd0, row_q[w].has};
      if (w == 0 || vq < vic_qual) begin
        vic_qual = vq;
        v_w      = w[WAY_W-1:0];
      end
    end
  end

  always_comb begin
    nxt       = '{v: 1'b1, gen: cur_q, sig: sig_q, depth: depth_q, flag: flag_q,
                  score: score_q, eval: eval_q, has: has_q,
                  mv: has_q ? mv_q : 16'd0};
    new_row   = row_q;
    old       = row_q[m_w];
    if (m_found) begin
      if (depth_q > old.depth ||
          (depth_q == old.depth && flag_q == 2'd0 && old.flag != 2'd0)) begin
        new_row[m_w] = nxt;
      end else begin
        if (eval_q != marker_q && old.eval == marker_q) begin
          new_row[m_w].eval = eval_q;
        end
        if (has_q && !old.has) begin
          new_row[m_w].has = 1'b1;
          new_row[m_w].mv  = mv_q;
        end
      end
    end else if (f_found) begin
      new_row[f_w] = nxt;
    end else begin
      new_row[v_w] = nxt;
    end
  end

  always_comb begin
    bs        = row_q[best_w];
    probe_res = '0;
    if (found) begin
      probe_res = {bs.gen == cur_q, bs.mv, bs.has, bs.eval, bs.score, bs.flag,
                   bs.depth, 1'b1};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_q <= mem[key_i[IDX_W-1:0]];
    end
    if (cmd_i.sweep) begin
      mem[sweep_cnt_q] <= '0;
    end else if (cmd_i.store_done) begin
      mem[bucket_q] <= new_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bucket_q <= key_i[IDX_W-1:0];
      sig_q    <= key_i[63:32];
      depth_q  <= nd;
      flag_q   <= bound_flag_i;
      score_q  <= score_i;
      eval_q   <= pos_eval_i;
      has_q    <= has_move_i;
      mv_q     <= best_move_i;
    end
    if (cmd_i.probe_done) begin
      out_q <= probe_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q    <= 16'h8000;
      cur_q       <= GEN_ONE;
      old_q       <= GEN_ONE;
      sweep_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        marker_q <= cfg_wdata_i;
      end
      if (cmd_i.gen_wrap) begin
        cur_q <= GEN_ONE;
        old_q <= GEN_ONE;
      end else if (cmd_i.gen_adv) begin
        cur_q <= cur_q + 8'd1;
        if (cmd_i.gen_clr) begin
          old_q <= cur_q + 8'd1;
        end
      end
      if (cmd_i.sweep) begin
        sweep_cnt_q <= sweep_cnt_q + 1'b1;
      end
      if (cmd_i.probe_done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.gen_at_max = (cur_q == GEN_MAX);
  assign sts_o.sweep_last = (sweep_cnt_q == IDX_W'(BUCKETS - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.cur_gen    = cur_q;
  assign sts_o.oldest_gen = old_q;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;

endmodule
`default_nettype wire

// File: hdl/clustered_hash_table_with_aging.sv
`default_nettype none
// Set-associative position table of 1024 buckets with 4 slots each, aged by an 8-bit
// generation. A probe or store request first reads the bucket row from the single-port
// bucket memory into a register, then scores the slots: a store writes the row back and a
// probe registers its answer, waiting only if its previous answer has not been taken.
// New-search and clear requests advance the generation. After reset, and whenever the
// generation wraps, the block runs a clearing pass over the bucket memory, one row per
// cycle, and takes no request meanwhile; the configuration write is accepted at any time.
module clustered_hash_table_with_aging (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [15:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // key[63:0], depth[71:64], bound_flag[73:72], score[89:74], pos_eval[105:90],
  // has_move[106], best_move[122:107], zero fill above.
  input  wire logic [127:0] s_axis_tdata,
  // cmd[1:0].
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // hit[0], hit_depth[6:1], hit_flag[8:7], hit_score[24:9], hit_eval[40:25],
  // hit_has_move[41], hit_move[57:42], hit_current[58], zero fill above.
  output logic [63:0]       m_axis_tdata
);
  import chtwa_pkg::*;

  ctl_cmd_t    cmd;
  ctl_sts_t    sts;
  logic [58:0] out_data;

  chtwa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  chtwa_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .key_i         (s_axis_tdata[63:0]),
    .depth_i       (s_axis_tdata[71:64]),
    .bound_flag_i  (s_axis_tdata[73:72]),
    .score_i       (s_axis_tdata[89:74]),
    .pos_eval_i    (s_axis_tdata[105:90]),
    .has_move_i    (s_axis_tdata[106]),
    .best_move_i   (s_axis_tdata[122:107]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (out_data)
  );

  assign m_axis_tdata = {5'd0, out_data};

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready &&
     (s_axis_tuser == CMD_PROBE || s_axis_tuser == CMD_STORE)) |=> !s_axis_tready)
    else $error("request accepted while previous one busy");

  a_gen_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.cur_gen != 8'd0 && sts.oldest_gen <= sts.cur_gen)
    else $error("generation window broken");

  a_store_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_STORE)
      |-> ##2 !$rose(m_axis_tvalid))
    else $error("store produced a result");

  a_no_sweep_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.sweep && (cmd.store_done || cmd.load)))
    else $error("clearing pass overlaps a request");
`endif

endmodule
`default_nettype wire
